FILE: rtl/assert_macros.svh
// Assertion macros shared by the feeder RTL.
// Expect clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define AFPF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons in the cycle after ante.
`define AFPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/afpf_pkg.sv
// Package of the audio jitter FIFO PWM feeder: types, codes, reset values
// and the duty conversion. No dependencies.
package afpf_pkg;

  typedef enum logic [2:0] {
    CFG_PWM_TOP     = 3'd0,
    CFG_ADMIT_SPACE = 3'd1,
    CFG_START_LEVEL = 3'd2,
    CFG_TICK_DIVIDE = 3'd3,
    CFG_LED_DIVIDE  = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_TDATA_W   = 32;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_TUSER_W  = 2;
  localparam int FILL_W       = 10;

  localparam logic [15:0] SAMPLE_OFFSET = 16'h8000;
  localparam int          DUTY_SHIFT    = 6;

  localparam logic [15:0] PWM_TOP_RST     = 16'd1499;
  localparam logic [9:0]  ADMIT_SPACE_RST = 10'd192;
  localparam logic [9:0]  START_LEVEL_RST = 10'd512;
  localparam logic [7:0]  TICK_DIVIDE_RST = 8'd2;
  localparam logic [15:0] LED_DIVIDE_RST  = 16'd8000;

  typedef struct packed {
    logic [15:0] pwm_top;
    logic [9:0]  admit_space;
    logic [9:0]  start_level;
    logic [7:0]  tick_divide;
    logic [15:0] led_divide;
  } cfg_t;

  typedef struct packed {
    logic              duty_valid;
    logic              sample_dropped;
    logic              activity_led;
    logic [FILL_W-1:0] fill_level;
    logic [15:0]       left_duty;
    logic [15:0]       right_duty;
  } result_t;

  function automatic logic [15:0] to_duty(input logic [15:0] s, input logic [15:0] top);
    logic [15:0] biased;
    logic [15:0] v;
    biased = s ^ SAMPLE_OFFSET;
    v      = biased >> DUTY_SHIFT;
    return (v > top) ? top : v;
  endfunction

endpackage

FILE: rtl/afpf_cfg.sv
// Configuration register bank of the feeder.
// Depends on afpf_pkg.
module afpf_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [afpf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [afpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output afpf_pkg::cfg_t                      cfg
);

  afpf_pkg::cfg_t cfg_r;
  afpf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (afpf_pkg::cfg_idx_t'(cfg_addr))
        afpf_pkg::CFG_PWM_TOP:     cfg_nxt.pwm_top     = cfg_wdata;
        afpf_pkg::CFG_ADMIT_SPACE: cfg_nxt.admit_space = cfg_wdata[9:0];
        afpf_pkg::CFG_START_LEVEL: cfg_nxt.start_level = cfg_wdata[9:0];
        afpf_pkg::CFG_TICK_DIVIDE: cfg_nxt.tick_divide = cfg_wdata[7:0];
        afpf_pkg::CFG_LED_DIVIDE:  cfg_nxt.led_divide  = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_top     <= afpf_pkg::PWM_TOP_RST;
      cfg_r.admit_space <= afpf_pkg::ADMIT_SPACE_RST;
      cfg_r.start_level <= afpf_pkg::START_LEVEL_RST;
      cfg_r.tick_divide <= afpf_pkg::TICK_DIVIDE_RST;
      cfg_r.led_divide  <= afpf_pkg::LED_DIVIDE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/afpf_ctrl.sv
// Ring control, sample store, drain and LED logic with one result stage.
// Depends on afpf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module afpf_ctrl #(
  parameter int FIFO_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  afpf_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  afpf_pkg::op_t       op,
  input  logic                packet_start,
  input  logic [15:0]         right_sample,
  input  logic [15:0]         left_sample,
  output logic                res_valid,
  input  logic                res_ready,
  output afpf_pkg::result_t   res
);

  localparam int           PW   = $clog2(FIFO_DEPTH);
  localparam int           EW   = PW + 10;
  localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);

  logic [31:0]   store [FIFO_DEPTH];

  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] count_r, count_nxt;
  logic          draining_r, draining_nxt;
  logic [7:0]    phase_r, phase_nxt;
  logic [15:0]   led_cnt_r, led_cnt_nxt;
  logic          led_r, led_nxt;
  logic          admitted_r, admitted_nxt;

  logic          acc;
  logic          push;
  logic          pop;
  logic          dropped;
  logic          have;
  logic [7:0]    phase_inc;
  logic [15:0]   led_inc;
  logic [PW-1:0] space;
  logic [31:0]   wr_word;

  logic          st_valid_r, st_valid_nxt;
  logic          st_pop_r;
  logic          st_drop_r;
  logic          st_led_r;
  logic [PW-1:0] st_count_r;
  logic [31:0]   rdata_r;

  assign in_ready = !st_valid_r || res_ready;
  assign acc      = in_valid && in_ready;
  assign space    = LAST - count_r;
  assign wr_word  = {afpf_pkg::to_duty(left_sample, cfg.pwm_top),
                     afpf_pkg::to_duty(right_sample, cfg.pwm_top)};

  always_comb begin
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    count_nxt    = count_r;
    draining_nxt = draining_r;
    phase_nxt    = phase_r;
    led_cnt_nxt  = led_cnt_r;
    led_nxt      = led_r;
    admitted_nxt = admitted_r;
    push         = 1'b0;
    pop          = 1'b0;
    dropped      = 1'b0;
    have         = 1'b0;
    phase_inc    = phase_r + 8'd1;
    led_inc      = led_cnt_r + 16'd1;
    if (acc) begin
      if (op == afpf_pkg::OP_SAMPLE) begin
        if (packet_start) begin
          admitted_nxt = (EW'(space) >= EW'(cfg.admit_space));
        end
        if (!admitted_nxt) begin
          dropped = 1'b1;
        end else begin
          if (count_r == LAST) begin
            dropped = 1'b1;
          end else begin
            push = 1'b1;
          end
          if (led_inc == cfg.led_divide) begin
            led_nxt     = !led_r;
            led_cnt_nxt = '0;
          end else begin
            led_cnt_nxt = led_inc;
          end
        end
      end else begin
        if (draining_r) begin
          have = (count_r != '0);
          if (!have) begin
            draining_nxt = 1'b0;
          end
        end else begin
          have = (EW'(count_r) > EW'(cfg.start_level));
          if (have) begin
            draining_nxt = 1'b1;
          end
        end
        if (phase_inc == cfg.tick_divide) begin
          phase_nxt = '0;
          pop       = have;
        end else begin
          phase_nxt = phase_inc;
        end
      end
    end
    if (push) begin
      wp_nxt    = (wp_r == LAST) ? '0 : wp_r + PW'(1);
      count_nxt = count_r + PW'(1);
    end
    if (pop) begin
      rp_nxt    = (rp_r == LAST) ? '0 : rp_r + PW'(1);
      count_nxt = count_r - PW'(1);
    end
  end

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (acc) begin
      st_valid_nxt = 1'b1;
    end else if (res_ready) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      count_r    <= '0;
      draining_r <= 1'b0;
      phase_r    <= '0;
      led_cnt_r  <= '0;
      led_r      <= 1'b0;
      admitted_r <= 1'b0;
      st_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      count_r    <= count_nxt;
      draining_r <= draining_nxt;
      phase_r    <= phase_nxt;
      led_cnt_r  <= led_cnt_nxt;
      led_r      <= led_nxt;
      admitted_r <= admitted_nxt;
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wp_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rdata_r    <= store[rp_r];
      st_pop_r   <= pop;
      st_drop_r  <= dropped;
      st_led_r   <= led_nxt;
      st_count_r <= count_nxt;
    end
  end

  assign res_valid          = st_valid_r;
  assign res.duty_valid     = st_pop_r;
  assign res.sample_dropped = st_drop_r;
  assign res.activity_led   = st_led_r;
  assign res.fill_level     = afpf_pkg::FILL_W'(st_count_r);
  assign res.right_duty     = st_pop_r ? rdata_r[15:0]  : 16'd0;
  assign res.left_duty      = st_pop_r ? rdata_r[31:16] : 16'd0;

  `AFPF_ASSERT_SAME(a_pop_nonempty, pop, count_r != '0)
  `AFPF_ASSERT_SAME(a_push_pop_excl, acc, !(push && pop))
  `AFPF_ASSERT_NEXT(a_push_count, push, count_r == $past(count_r) + PW'(1))
  `AFPF_ASSERT_SAME(a_drop_no_push, dropped, !push && op == afpf_pkg::OP_SAMPLE)

endmodule

FILE: rtl/afpf_skid.sv
// Output register with skid entry for the result channel.
// Depends on afpf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module afpf_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  afpf_pkg::result_t up_res,
  output logic              dn_valid,
  input  logic              dn_ready,
  output afpf_pkg::result_t dn_res
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  afpf_pkg::result_t out_res_r, out_res_nxt;
  afpf_pkg::result_t skid_res_r, skid_res_nxt;
  logic              push;
  logic              take;

  assign up_ready = !skid_valid_r;
  assign push     = up_valid && up_ready;
  assign take     = out_valid_r && dn_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_res_nxt   = up_res;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_res_nxt   = up_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign dn_valid = out_valid_r;
  assign dn_res   = out_res_r;

  `AFPF_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r)
  `AFPF_ASSERT_NEXT(a_stall_fills_skid, out_valid_r && !dn_ready && push, skid_valid_r)

endmodule

FILE: rtl/audio_jitter_fifo_pwm_feeder_top.sv
// Top level of the audio jitter FIFO PWM feeder.
// Depends on afpf_pkg, afpf_cfg, afpf_ctrl and afpf_skid.
//
//   channel | ports            | tdata (low bit up)                 | tuser (low bit up)
//   in      | in_t*            | right_sample, left_sample          | op, packet_start
//   out     | out_t*           | right_duty, left_duty, activity_led,
//           |                  | fill_level, zero pad               | duty_valid, sample_dropped
//   cfg     | cfg_we/addr/wdata| register index 0..4, 16-bit data   | -
//
// One item per cycle while the output takes results; an accepted request is registered
// with the ring update and the registered store read in the result stage, then in the output stage.
// Reset clears pointers, fill, counters and flags; store contents stay unknown.
// A stalled output holds three results (result stage, output register, skid entry);
// input stalls after that.
module audio_jitter_fifo_pwm_feeder_top #(
  parameter int FIFO_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [afpf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [afpf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [afpf_pkg::IN_TDATA_W-1:0]      in_tdata,   // right_sample, left_sample
  input  logic [afpf_pkg::IN_TUSER_W-1:0]      in_tuser,   // op, packet_start
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [afpf_pkg::OUT_TDATA_W-1:0]     out_tdata,  // right_duty, left_duty,
                                                           // activity_led, fill_level, pad
  output logic [afpf_pkg::OUT_TUSER_W-1:0]     out_tuser   // duty_valid, sample_dropped
);

  afpf_pkg::cfg_t    cfg;
  afpf_pkg::result_t st_res;
  afpf_pkg::result_t dn_res;
  logic              st_valid;
  logic              st_ready;

  afpf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  afpf_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .op           (afpf_pkg::op_t'(in_tuser[0])),
    .packet_start (in_tuser[1]),
    .right_sample (in_tdata[15:0]),
    .left_sample  (in_tdata[31:16]),
    .res_valid    (st_valid),
    .res_ready    (st_ready),
    .res          (st_res)
  );

  afpf_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (st_valid),
    .up_ready (st_ready),
    .up_res   (st_res),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_res   (dn_res)
  );

  assign out_tdata[15:0]  = dn_res.right_duty;
  assign out_tdata[31:16] = dn_res.left_duty;
  assign out_tdata[32]    = dn_res.activity_led;
  assign out_tdata[42:33] = dn_res.fill_level;
  assign out_tdata[47:43] = 5'd0;
  assign out_tuser[0]     = dn_res.duty_valid;
  assign out_tuser[1]     = dn_res.sample_dropped;

endmodule

FILE: verif/tb_audio_jitter_fifo_pwm_feeder_top.sv
// Self-checking testbench for audio_jitter_fifo_pwm_feeder_top: directed and random
// sample/tick streams, predicted in-bench and checked field by field. Needs afpf_pkg
// and the feeder RTL only.
module tb_audio_jitter_fifo_pwm_feeder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 1024;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    afpf_pkg::op_t op;
    logic          packet_start;
    logic [15:0]   right_sample;
    logic [15:0]   left_sample;
  } feed_item_t;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [afpf_pkg::CFG_ADDR_W-1:0]  cfg_addr;
  logic [afpf_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [afpf_pkg::IN_TDATA_W-1:0]  in_tdata;   // right_sample, left_sample
  logic [afpf_pkg::IN_TUSER_W-1:0]  in_tuser;   // op, packet_start
  logic                             out_tvalid;
  logic                             out_tready;
  logic [afpf_pkg::OUT_TDATA_W-1:0] out_tdata;  // right_duty, left_duty, activity_led,
                                                // fill_level, pad
  logic [afpf_pkg::OUT_TUSER_W-1:0] out_tuser;  // duty_valid, sample_dropped

  audio_jitter_fifo_pwm_feeder_top #(.FIFO_DEPTH(RING_DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predictor state
  logic [31:0]       duty_store [RING_DEPTH];
  int                wr_ptr;
  int                rd_ptr;
  bit                playing;
  logic [7:0]        tick_cnt;
  logic [15:0]       blink_cnt;
  bit                led_on;
  bit                pkt_ok;
  afpf_pkg::cfg_t    cur_cfg;

  afpf_pkg::result_t duty_expect_q [$];
  int                err_count;
  int                req_count;
  int                pop_count;
  int                drop_count;
  int                cfg_sets;
  bit                tx_idle_en;
  bit                rx_idle_en;
  int                rx_hold_req;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int ring_fill();
    return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
  endfunction

  function automatic logic [15:0] scale_duty(input logic [15:0] s, input logic [15:0] top);
    int lvl;
    lvl = (int'($signed(s)) + 32768) / 64;
    return (lvl > int'(top)) ? top : 16'(lvl);
  endfunction

  function automatic afpf_pkg::result_t predict_duty(input feed_item_t it);
    afpf_pkg::result_t r;
    int                fill;
    bit                pop;
    r = '0;
    if (it.op == afpf_pkg::OP_SAMPLE) begin
      if (it.packet_start)
        pkt_ok = (RING_DEPTH - 1 - ring_fill()) >= int'(cur_cfg.admit_space);
      if (!pkt_ok) begin
        r.sample_dropped = 1'b1;
      end else begin
        if ((wr_ptr + 1) % RING_DEPTH == rd_ptr) begin
          r.sample_dropped = 1'b1;
        end else begin
          duty_store[wr_ptr] = {scale_duty(it.left_sample, cur_cfg.pwm_top),
                                scale_duty(it.right_sample, cur_cfg.pwm_top)};
          wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        end
        blink_cnt = blink_cnt + 16'd1;
        if (blink_cnt == cur_cfg.led_divide) begin
          led_on    = !led_on;
          blink_cnt = '0;
        end
      end
    end else begin
      fill = ring_fill();
      if (playing) begin
        pop = (fill != 0);
        if (!pop) playing = 1'b0;
      end else begin
        pop = (fill > int'(cur_cfg.start_level));
        if (pop) playing = 1'b1;
      end
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt == cur_cfg.tick_divide) begin
        tick_cnt = '0;
        if (pop) begin
          r.right_duty = duty_store[rd_ptr][15:0];
          r.left_duty  = duty_store[rd_ptr][31:16];
          r.duty_valid = 1'b1;
          rd_ptr       = (rd_ptr + 1) % RING_DEPTH;
        end
      end
    end
    r.activity_led = led_on;
    r.fill_level   = afpf_pkg::FILL_W'(ring_fill());
    return r;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic feed_item_t make_item(input afpf_pkg::op_t op, input logic start,
                                           input logic [15:0] r, input logic [15:0] l);
    feed_item_t it;
    it.op           = op;
    it.packet_start = start;
    it.right_sample = r;
    it.left_sample  = l;
    return it;
  endfunction

  // enter and leave at a falling edge; in_tvalid stays high for a following request
  task automatic send_request(input feed_item_t it);
    while (tx_idle_en && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.left_sample, it.right_sample};
    in_tuser  <= {it.packet_start, it.op};
    do @(posedge clk); while (!in_tready);
    duty_expect_q.push_back(predict_duty(it));
    req_count++;
    @(negedge clk);
  endtask

  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (duty_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input afpf_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      afpf_pkg::CFG_PWM_TOP:     cur_cfg.pwm_top     = val;
      afpf_pkg::CFG_ADMIT_SPACE: cur_cfg.admit_space = val[9:0];
      afpf_pkg::CFG_START_LEVEL: cur_cfg.start_level = val[9:0];
      afpf_pkg::CFG_TICK_DIVIDE: cur_cfg.tick_divide = val[7:0];
      afpf_pkg::CFG_LED_DIVIDE:  cur_cfg.led_divide  = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] pwm_top, input logic [15:0] admit,
                                input logic [15:0] start, input logic [15:0] tick_div,
                                input logic [15:0] led_div);
    settle_idle();
    cfg_write(afpf_pkg::CFG_PWM_TOP, pwm_top);
    cfg_write(afpf_pkg::CFG_ADMIT_SPACE, admit);
    cfg_write(afpf_pkg::CFG_START_LEVEL, start);
    cfg_write(afpf_pkg::CFG_TICK_DIVIDE, tick_div);
    cfg_write(afpf_pkg::CFG_LED_DIVIDE, led_div);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_sets++;
  endtask

  // packets of samples led by a start flag, ticks mixed in, some broken framing
  task automatic run_traffic(input int n, input int tick_pct, input int pkt_max);
    feed_item_t it;
    int         pkt_left;
    pkt_left = 0;
    repeat (n) begin
      if ($urandom_range(99) < tick_pct)
        it.op = afpf_pkg::OP_TICK;
      else
        it.op = afpf_pkg::OP_SAMPLE;
      it.packet_start = 1'b0;
      it.right_sample = rand_sample();
      it.left_sample  = rand_sample();
      if (it.op == afpf_pkg::OP_TICK) begin
        it.packet_start = ($urandom_range(9) == 0);
      end else begin
        if (pkt_left == 0) begin
          pkt_left        = $urandom_range(pkt_max, 1);
          it.packet_start = ($urandom_range(19) != 0);
        end else begin
          it.packet_start = ($urandom_range(39) == 0);
        end
        pkt_left--;
      end
      send_request(it);
    end
  endtask

  task automatic test_unadmitted_and_empty();
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b0, 16'h1234, 16'hedcb));
    send_request(make_item(afpf_pkg::OP_TICK, 1'b1, 16'h0000, 16'h0000));
    send_request(make_item(afpf_pkg::OP_TICK, 1'b0, 16'hffff, 16'hffff));
  endtask

  task automatic test_conversion_and_clamp();
    apply_settings(16'd700, 16'd0, 16'd0, 16'd1, 16'd2);
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b1, 16'h8000, 16'h7fff));
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b0, 16'h7fff, 16'h8000));
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b0, 16'h0000, 16'hffff));
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b0, 16'h2f00, 16'h2f40));
    repeat (6) send_request(make_item(afpf_pkg::OP_TICK, 1'b0, 16'h5555, 16'haaaa));
  endtask

  task automatic test_admission();
    apply_settings(16'd1499, 16'd1023, 16'd1023, 16'd2, 16'd1);
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b1, 16'h0100, 16'hff00));
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b0, 16'h0200, 16'hfe00));
    apply_settings(16'd1499, 16'd1022, 16'd1023, 16'd2, 16'd1);
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b1, 16'h0300, 16'hfd00));
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b1, 16'h0400, 16'hfc00));
    send_request(make_item(afpf_pkg::OP_SAMPLE, 1'b1, 16'h0500, 16'hfb00));
  endtask

  task automatic test_random_mix();
    apply_settings(16'd1499, 16'd192, 16'd64, 16'd2, 16'd5);
    run_traffic(180, 45, 12);
  endtask

  task automatic test_zero_clamp();
    apply_settings(16'd0, 16'd1, 16'd0, 16'd1, 16'd1);
    run_traffic(100, 50, 4);
  endtask

  task automatic test_ring_full();
    apply_settings(16'd65535, 16'd0, 16'd1023, 16'd255, 16'd65535);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_traffic(1100, 2, 48);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_drain_out();
    apply_settings(16'd800, 16'd340, 16'd0, 16'd1, 16'd3);
    run_traffic(250, 80, 16);
  endtask

  task automatic test_divider_wrap();
    apply_settings(16'd1023, 16'd0, 16'd10, 16'd0, 16'd7);
    run_traffic(180, 85, 8);
  endtask

  task automatic test_backpressure();
    apply_settings(afpf_pkg::PWM_TOP_RST, 16'(afpf_pkg::ADMIT_SPACE_RST),
                   16'(afpf_pkg::START_LEVEL_RST), 16'(afpf_pkg::TICK_DIVIDE_RST),
                   afpf_pkg::LED_DIVIDE_RST);
    tx_idle_en  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    run_traffic(130, 30, 10);
    tx_idle_en  = 1'b1;
  endtask

  // receiver: random stalls, or a long hold when requested
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_idle_en && $urandom_range(99) < 26) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    afpf_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (duty_expect_q.size() == 0) begin
        err_count++;
        $display("%0t ns: unexpected result, expected none actual %0h/%0h",
                 $time, out_tdata, out_tuser);
      end else begin
        want = duty_expect_q.pop_front();
        if (want.duty_valid) pop_count++;
        if (want.sample_dropped) drop_count++;
        check_field("right_duty", int'(want.right_duty), int'(out_tdata[15:0]));
        check_field("left_duty", int'(want.left_duty), int'(out_tdata[31:16]));
        check_field("activity_led", int'(want.activity_led), int'(out_tdata[32]));
        check_field("fill_level", int'(want.fill_level), int'(out_tdata[42:33]));
        check_field("duty_valid", int'(want.duty_valid), int'(out_tuser[0]));
        check_field("sample_dropped", int'(want.sample_dropped), int'(out_tuser[1]));
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** audio_jitter_fifo_pwm_feeder_top: FAILED **");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    rx_hold_req = 0;
    err_count   = 0;
    req_count   = 0;
    pop_count   = 0;
    drop_count  = 0;
    cfg_sets    = 1;
    wr_ptr      = 0;
    rd_ptr      = 0;
    playing     = 1'b0;
    tick_cnt    = '0;
    blink_cnt   = '0;
    led_on      = 1'b0;
    pkt_ok      = 1'b0;
    cur_cfg     = '{pwm_top: afpf_pkg::PWM_TOP_RST,
                    admit_space: afpf_pkg::ADMIT_SPACE_RST,
                    start_level: afpf_pkg::START_LEVEL_RST,
                    tick_divide: afpf_pkg::TICK_DIVIDE_RST,
                    led_divide: afpf_pkg::LED_DIVIDE_RST};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unadmitted_and_empty();
    test_conversion_and_clamp();
    test_admission();
    test_random_mix();
    test_zero_clamp();
    test_ring_full();
    test_drain_out();
    test_divider_wrap();
    test_backpressure();

    settle_idle();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests under %0d register settings: %0d pairs popped, %0d dropped.",
             req_count, cfg_sets, pop_count, drop_count);
    $display("Covered clamping, packet admission, ring overflow, drain hysteresis %s",
             "and a long output stall.");
    if (err_count == 0)
      $display("** audio_jitter_fifo_pwm_feeder_top: PASSED **");
    else
      $display("** audio_jitter_fifo_pwm_feeder_top: FAILED **");
    $finish;
  end

endmodule
